@@ hdl/rcbp_pkg.sv @@
package rcbp_pkg;

   // Pool geometry
   localparam int NUM_BUFFERS = 16;
   localparam int COUNT_BITS  = 8;
   localparam int IDX_BITS    = $clog2(NUM_BUFFERS);
   localparam int FREE_BITS   = $clog2(NUM_BUFFERS + 1);

   // Port field widths
   localparam int FIELD_IDX_BITS   = 4;
   localparam int FIELD_COUNT_BITS = 8;
   localparam int CMD_BITS         = 2;
   localparam int REQ_DATA_BITS    = 8;
   localparam int RSP_DATA_BITS    = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_ADD_REF = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   // One request word after unpacking
   typedef struct packed {
      logic [CMD_BITS-1:0]       command;
      logic [FIELD_IDX_BITS-1:0] buffer_index;
   } req_type;

   // One result word before packing
   typedef struct packed {
      logic                        error;
      logic [FIELD_COUNT_BITS-1:0] count_after;
      logic                        released;
      logic [FIELD_IDX_BITS-1:0]   granted_index;
      logic                        granted;
   } rsp_type;

endpackage

@@ hdl/rcbp_pool.sv @@
module rcbp_pool (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  rcbp_pkg::req_type req,
   output rcbp_pkg::rsp_type rsp
);
   import rcbp_pkg::*;

   logic [IDX_BITS-1:0]   free_list_ff [NUM_BUFFERS];
   logic [COUNT_BITS-1:0] ref_counts_ff [NUM_BUFFERS];
   logic [IDX_BITS-1:0]   free_head_ff;
   logic [IDX_BITS-1:0]   free_tail_ff;
   logic [FREE_BITS-1:0]  free_count_ff;

   logic [IDX_BITS-1:0]   free_head_in;
   logic [IDX_BITS-1:0]   free_tail_in;
   logic [FREE_BITS-1:0]  free_count_in;

   logic                  list_we;
   logic                  count_we;
   logic [IDX_BITS-1:0]   count_addr;
   logic [COUNT_BITS-1:0] count_wdata;

   logic [IDX_BITS-1:0]   idx;
   logic                  idx_ok;
   logic [COUNT_BITS-1:0] cur_count;
   logic [IDX_BITS-1:0]   head_entry;
   logic                  list_empty;
   logic                  list_full;

   assign idx        = IDX_BITS'(req.buffer_index);
   assign idx_ok     = 32'(req.buffer_index) < NUM_BUFFERS;
   assign cur_count  = ref_counts_ff[idx];
   assign head_entry = free_list_ff[free_head_ff];
   assign list_empty = free_count_ff == '0;
   assign list_full  = free_count_ff == FREE_BITS'(NUM_BUFFERS);

   // Decode the command and form the state update and the result word
   always_comb begin
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_count_in = free_count_ff;
      list_we       = 1'b0;
      count_we      = 1'b0;
      count_addr    = idx;
      count_wdata   = cur_count;
      rsp           = '0;
      case (req.command)
         CMD_ALLOC: begin
            if (!list_empty) begin
               free_head_in = (free_head_ff == IDX_BITS'(NUM_BUFFERS - 1)) ?
                              '0 : free_head_ff + 1'b1;
               free_count_in     = free_count_ff - 1'b1;
               count_we          = 1'b1;
               count_addr        = head_entry;
               count_wdata       = COUNT_BITS'(1);
               rsp.granted       = 1'b1;
               rsp.granted_index = FIELD_IDX_BITS'(head_entry);
               rsp.count_after   = FIELD_COUNT_BITS'(1);
            end
         end
         CMD_ADD_REF: begin
            if (idx_ok) begin
               count_we = 1'b1;
               if (cur_count == COUNT_MAX) begin
                  count_wdata = COUNT_MAX;
                  rsp.error   = 1'b1;
               end else begin
                  count_wdata = cur_count + 1'b1;
               end
               rsp.count_after = FIELD_COUNT_BITS'(count_wdata);
            end
         end
         CMD_RELEASE: begin
            if (idx_ok) begin
               if (cur_count == '0) begin
                  rsp.error = 1'b1;
               end else if (cur_count == COUNT_BITS'(1)) begin
                  // Last reference: clear and push back unless the list is full
                  count_we    = 1'b1;
                  count_wdata = '0;
                  if (!list_full) begin
                     list_we      = 1'b1;
                     free_tail_in = (free_tail_ff == IDX_BITS'(NUM_BUFFERS - 1)) ?
                                    '0 : free_tail_ff + 1'b1;
                     free_count_in = free_count_ff + 1'b1;
                     rsp.released  = 1'b1;
                  end
               end else begin
                  count_we        = 1'b1;
                  count_wdata     = cur_count - 1'b1;
                  rsp.count_after = FIELD_COUNT_BITS'(count_wdata);
               end
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

   // Commit the update when the word advances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            free_list_ff[i]  <= IDX_BITS'(i);
            ref_counts_ff[i] <= '0;
         end
         free_head_ff  <= '0;
         free_tail_ff  <= '0;
         free_count_ff <= FREE_BITS'(NUM_BUFFERS);
      end else if (step) begin
         if (list_we) begin
            free_list_ff[free_tail_ff] <= idx;
         end
         if (count_we) begin
            ref_counts_ff[count_addr] <= count_wdata;
         end
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_count_ff <= free_count_in;
      end
   end

endmodule

@@ hdl/refcounted_buffer_pool_core.sv @@
// An accepted request word is held in the input register; its result word is
// held in the result register, which drives rsp_. Throughput: one request word
// per cycle unless rsp_tready stalls; each word does its single
// read-modify-write of the pool state between the two registers.
// Reset (synchronous, active high): free list holds buffers 0..15 in order,
// all reference counts are zero, both channels empty.
module refcounted_buffer_pool_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] command, [5:2] buffer_index, [7:6] zero
   input  logic [rcbp_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] granted, [4:1] granted_index, [5] released, [13:6] count_after,
   // [14] error, [15] zero
   output logic [rcbp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import rcbp_pkg::*;

   logic    in_valid_ff;
   req_type in_word_ff;
   logic    out_valid_ff;
   rsp_type out_word_ff;

   logic    advance;
   logic    req_take;
   rsp_type step_rsp;

   // Move the held word on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   rcbp_pool u_pool (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_word_ff),
      .rsp   (step_rsp)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.command      <= req_tdata[CMD_BITS-1:0];
         in_word_ff.buffer_index <= req_tdata[CMD_BITS +: FIELD_IDX_BITS];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_word_ff);

   // A held word whose result slot is open moves on in the same cycle
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after advance");

   // Back pressure only while both registers are full and the output stalls
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("request side stalled without cause");

   // A granted allocate carries a count of one and no other flag
   a_grant_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.granted) |->
      (out_word_ff.count_after == FIELD_COUNT_BITS'(1) &&
       !out_word_ff.error && !out_word_ff.released))
      else $error("granted result carries inconsistent fields");

   // A return to the free list always leaves a zero count
   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.released) |->
      (out_word_ff.count_after == '0 && !out_word_ff.error))
      else $error("released result carries nonzero count or error");

endmodule
